// ===== sv/sadpcm_pkg.sv =====
// ---------------------------------------------------------------------------
// sadpcm_pkg
// shared types and constants for the stereo adpcm stream decoder
// ---------------------------------------------------------------------------
package sadpcm_pkg;

    localparam int POS_W        = 5;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 32;
    localparam int FRAME_CNT_W  = 32;
    localparam int HIST_W       = 24;
    localparam int PRED_W       = 22;
    localparam int SAMPLE_W     = 16;
    localparam int VOL_W        = 8;

    localparam logic [POS_W-1:0] POS_LEFT_HDR   = 5'd0;
    localparam logic [POS_W-1:0] POS_RIGHT_HDR  = 5'd1;
    localparam logic [POS_W-1:0] POS_FIRST_FRAME = 5'd4;
    localparam logic [POS_W-1:0] POS_LAST       = 5'd31;

    localparam logic [FRAME_CNT_W-1:0] BLOCK_FRAMES = 32'd28;

    // predictor taps
    localparam logic signed [7:0] COEF_P1_A = 8'sd60;
    localparam logic signed [7:0] COEF_P2_A = 8'sd115;
    localparam logic signed [7:0] COEF_P2_B = 8'sd52;
    localparam logic signed [7:0] COEF_P3_A = 8'sd98;
    localparam logic signed [7:0] COEF_P3_B = 8'sd55;

    localparam logic signed [PRED_W-1:0]   PRED_MAX   = 22'sh1fffff;
    localparam logic signed [PRED_W-1:0]   PRED_MIN   = {1'b1, 21'd0};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, 15'd0};

    typedef enum logic [3:0] {
        PRED_NONE = 4'd0,
        PRED_ONE  = 4'd1,
        PRED_TWO  = 4'd2,
        PRED_THREE = 4'd3
    } pred_sel_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_VOL_LEFT  = 2'd0,
        CFG_VOL_RIGHT = 2'd1,
        CFG_TRIGGER   = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic accept;
        logic pred_en;
        logic samp_en;
        logic mul_en;
        logic out_load;
    } sadpcm_cmd_t;

    typedef struct packed {
        logic frame_byte;
    } sadpcm_status_t;

endpackage

// ===== sv/stereo_adpcm_stream_decoder_unit.sv =====
// ---------------------------------------------------------------------------
// stereo_adpcm_stream_decoder_unit
// byte-serial stereo adpcm block decoder with volume and frame counting
// ---------------------------------------------------------------------------
// path: a frame byte (block positions 4 to 31) passes predict, sample, gain
//   and divide; the output load waits while the held output is not taken
// flow: header and pad bytes are taken while idle; a frame byte holds off the
//   next byte until the sequencer has walked it through the shared decode lanes
// reset: rst_n clears position, headers, histories, frame count and volumes
// ---------------------------------------------------------------------------
module stereo_adpcm_stream_decoder_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,   // stream_byte
    input  logic                                s_axis_tuser,   // new_stream
    // output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // left_sample [15:0], right_sample [31:16], frames_played [63:32]
    output logic [63:0]                         m_axis_tdata,
    output logic                                m_axis_tlast,   // block_end
    output logic                                m_axis_tuser,   // trigger_reached
    // configuration writes
    input  logic                                cfg_we,
    input  logic [sadpcm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [sadpcm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import sadpcm_pkg::*;

    sadpcm_cmd_t                cmd;
    sadpcm_status_t             status;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic [FRAME_CNT_W-1:0]     frames_played;

    // sequencer: one frame at a time through predict, sample, gain, divide
    sadpcm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    // block parsing, both channel lanes and the held output request
    sadpcm_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .stream_byte     (s_axis_tdata),
        .new_stream      (s_axis_tuser),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .left_sample     (left_sample),
        .right_sample    (right_sample),
        .block_end       (m_axis_tlast),
        .frames_played   (frames_played),
        .trigger_reached (m_axis_tuser)
    );

    // pack the output request, first field in the low bits
    assign m_axis_tdata = {frames_played, right_sample, left_sample};

endmodule

// ===== sv/sadpcm_ctrl.sv =====
// ---------------------------------------------------------------------------
// sadpcm_ctrl
// sequencer: accept, predict, sample, scale, output load
// ---------------------------------------------------------------------------
module sadpcm_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    output logic                       out_valid,
    input  logic                       out_ready,
    input  sadpcm_pkg::sadpcm_status_t status,
    output sadpcm_pkg::sadpcm_cmd_t    cmd
);
    import sadpcm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRED,
        ST_SAMP,
        ST_MUL,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid && status.frame_byte)
                begin
                    state_next = ST_PRED;
                end
            end
            ST_PRED:
            begin
                cmd.pred_en = 1'b1;
                state_next  = ST_SAMP;
            end
            ST_SAMP:
            begin
                cmd.samp_en = 1'b1;
                state_next  = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== sv/sadpcm_datapath.sv =====
// ---------------------------------------------------------------------------
// sadpcm_datapath
// block parsing, two-lane adpcm decode, volume scaling and output register
// ---------------------------------------------------------------------------
module sadpcm_datapath (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  sadpcm_pkg::sadpcm_cmd_t                 cmd,
    output sadpcm_pkg::sadpcm_status_t              status,
    input  logic [7:0]                              stream_byte,
    input  logic                                    new_stream,
    input  logic                                    cfg_we,
    input  logic [sadpcm_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [sadpcm_pkg::CFG_DATA_W-1:0]       cfg_data,
    output logic signed [sadpcm_pkg::SAMPLE_W-1:0]  left_sample,
    output logic signed [sadpcm_pkg::SAMPLE_W-1:0]  right_sample,
    output logic                                    block_end,
    output logic [sadpcm_pkg::FRAME_CNT_W-1:0]      frames_played,
    output logic                                    trigger_reached
);
    import sadpcm_pkg::*;

    // configuration
    logic [VOL_W-1:0]       vol_reg [2];
    logic [FRAME_CNT_W-1:0] trigger_reg;

    // block state
    logic [POS_W-1:0]       pos_reg;
    logic [POS_W-1:0]       pos_eff;
    logic [7:0]             header_reg [2];
    logic signed [HIST_W-1:0] hist_reg [2][2];
    logic [FRAME_CNT_W-1:0] frame_cnt_reg;

    // per-item registers
    logic [7:0]             code_byte_reg;
    logic                   last_reg;
    logic signed [32:0]     pred_reg [2];
    logic signed [SAMPLE_W-1:0] samp_reg [2];
    logic signed [24:0]     prod_reg [2];

    // output register
    logic signed [SAMPLE_W-1:0] out_samp_reg [2];
    logic                   out_end_reg;
    logic [FRAME_CNT_W-1:0] out_cnt_reg;
    logic                   out_trig_reg;

    // lane logic
    logic signed [7:0]      coef_a [2];
    logic signed [7:0]      coef_b [2];
    logic signed [31:0]     tap_a [2];
    logic signed [31:0]     tap_b [2];
    logic signed [32:0]     pred_sum [2];
    logic signed [33:0]     pred_rnd [2];
    logic signed [33:0]     pred_sh [2];
    logic signed [PRED_W-1:0] pred_clip [2];
    logic [3:0]             nib [2];
    logic signed [15:0]     step_val [2];
    logic signed [15:0]     step_sh [2];
    logic signed [22:0]     s_val [2];
    logic signed [16:0]     s_out [2];
    logic signed [SAMPLE_W-1:0] s_clip [2];
    logic signed [24:0]     prod_next [2];
    logic                   neg [2];
    logic [24:0]            mag_full [2];
    logic [23:0]            mag [2];
    logic [39:0]            recip [2];
    logic [16:0]            q0 [2];
    logic [25:0]            rem [2];
    logic [16:0]            q_fix [2];
    logic [16:0]            q_sgn [2];
    logic [FRAME_CNT_W-1:0] cnt_new;
    logic                   trig_new;

    assign pos_eff           = new_stream ? POS_LEFT_HDR : pos_reg;
    assign status.frame_byte = (pos_eff >= POS_FIRST_FRAME);

    always_comb
    begin
        for (int ch = 0; ch < 2; ch++)
        begin
            // prediction taps
            case (pred_sel_t'(header_reg[ch][7:4]))
                PRED_ONE:
                begin
                    coef_a[ch] = COEF_P1_A;
                    coef_b[ch] = 8'sd0;
                end
                PRED_TWO:
                begin
                    coef_a[ch] = COEF_P2_A;
                    coef_b[ch] = COEF_P2_B;
                end
                PRED_THREE:
                begin
                    coef_a[ch] = COEF_P3_A;
                    coef_b[ch] = COEF_P3_B;
                end
                default:
                begin
                    coef_a[ch] = 8'sd0;
                    coef_b[ch] = 8'sd0;
                end
            endcase
            tap_a[ch]    = hist_reg[ch][0] * coef_a[ch];
            tap_b[ch]    = hist_reg[ch][1] * coef_b[ch];
            pred_sum[ch] = 33'(tap_a[ch]) - 33'(tap_b[ch]);

            // round, clamp to 22 bits, add scaled nibble
            pred_rnd[ch] = 34'(pred_reg[ch]) + 34'sd32;
            pred_sh[ch]  = pred_rnd[ch] >>> 6;
            if (pred_sh[ch] > 34'(PRED_MAX))
            begin
                pred_clip[ch] = PRED_MAX;
            end
            else if (pred_sh[ch] < 34'(PRED_MIN))
            begin
                pred_clip[ch] = PRED_MIN;
            end
            else
            begin
                pred_clip[ch] = pred_sh[ch][PRED_W-1:0];
            end
            nib[ch]      = (ch == 0) ? code_byte_reg[3:0] : code_byte_reg[7:4];
            step_val[ch] = {nib[ch], 12'd0};
            step_sh[ch]  = step_val[ch] >>> header_reg[ch][3:0];
            s_val[ch]    = 23'($signed({step_sh[ch], 6'd0})) + 23'(pred_clip[ch]);
            s_out[ch]    = 17'(s_val[ch] >>> 6);
            if (s_out[ch] > 17'(SAMPLE_MAX))
            begin
                s_clip[ch] = SAMPLE_MAX;
            end
            else if (s_out[ch] < 17'(SAMPLE_MIN))
            begin
                s_clip[ch] = SAMPLE_MIN;
            end
            else
            begin
                s_clip[ch] = s_out[ch][SAMPLE_W-1:0];
            end

            // volume gain
            prod_next[ch] = samp_reg[ch] * $signed({1'b0, vol_reg[ch]});

            // divide by 255 toward zero: reciprocal estimate plus one correction
            neg[ch]      = prod_reg[ch][24];
            mag_full[ch] = neg[ch] ? 25'(-prod_reg[ch]) : 25'(prod_reg[ch]);
            mag[ch]      = mag_full[ch][23:0];
            recip[ch]    = ({16'd0, mag[ch]} << 15) + ({16'd0, mag[ch]} << 7);
            q0[ch]       = recip[ch][39:23];
            rem[ch]      = 26'(mag[ch]) - (26'({q0[ch], 8'd0}) - 26'(q0[ch]));
            q_fix[ch]    = (rem[ch] >= 26'd255) ? q0[ch] + 17'd1 : q0[ch];
            q_sgn[ch]    = neg[ch] ? 17'(-q_fix[ch]) : q_fix[ch];
        end

        cnt_new  = last_reg ? frame_cnt_reg + BLOCK_FRAMES : frame_cnt_reg;
        trig_new = last_reg && (trigger_reg != '0) && (cnt_new >= trigger_reg);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vol_reg[0]    <= '0;
            vol_reg[1]    <= '0;
            trigger_reg   <= '0;
            pos_reg       <= '0;
            header_reg[0] <= '0;
            header_reg[1] <= '0;
            frame_cnt_reg <= '0;
            for (int ch = 0; ch < 2; ch++)
            begin
                hist_reg[ch][0] <= '0;
                hist_reg[ch][1] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_VOL_LEFT:  vol_reg[0]  <= cfg_data[VOL_W-1:0];
                    CFG_VOL_RIGHT: vol_reg[1]  <= cfg_data[VOL_W-1:0];
                    CFG_TRIGGER:   trigger_reg <= cfg_data[FRAME_CNT_W-1:0];
                    default:       ;
                endcase
            end

            if (cmd.accept)
            begin
                pos_reg <= pos_eff + 5'd1;
                if (pos_eff == POS_LEFT_HDR)
                begin
                    header_reg[0] <= stream_byte;
                end
                if (pos_eff == POS_RIGHT_HDR)
                begin
                    header_reg[1] <= stream_byte;
                end
                if (new_stream)
                begin
                    frame_cnt_reg <= '0;
                    for (int ch = 0; ch < 2; ch++)
                    begin
                        hist_reg[ch][0] <= '0;
                        hist_reg[ch][1] <= '0;
                    end
                end
            end

            if (cmd.samp_en)
            begin
                for (int ch = 0; ch < 2; ch++)
                begin
                    hist_reg[ch][1] <= hist_reg[ch][0];
                    hist_reg[ch][0] <= HIST_W'(s_val[ch]);
                end
            end

            if (cmd.out_load)
            begin
                frame_cnt_reg <= cnt_new;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            code_byte_reg <= stream_byte;
            last_reg      <= (pos_eff == POS_LAST);
        end
        for (int ch = 0; ch < 2; ch++)
        begin
            if (cmd.pred_en)
            begin
                pred_reg[ch] <= pred_sum[ch];
            end
            if (cmd.samp_en)
            begin
                samp_reg[ch] <= s_clip[ch];
            end
            if (cmd.mul_en)
            begin
                prod_reg[ch] <= prod_next[ch];
            end
            if (cmd.out_load)
            begin
                out_samp_reg[ch] <= q_sgn[ch][SAMPLE_W-1:0];
            end
        end
        if (cmd.out_load)
        begin
            out_end_reg  <= last_reg;
            out_cnt_reg  <= cnt_new;
            out_trig_reg <= trig_new;
        end
    end

    assign left_sample     = out_samp_reg[0];
    assign right_sample    = out_samp_reg[1];
    assign block_end       = out_end_reg;
    assign frames_played   = out_cnt_reg;
    assign trigger_reached = out_trig_reg;

endmodule
